### sv/rotary_encoder_with_button_debounce_assert.svh
// Assertion macros for the rotary encoder block.
`ifndef ROTARY_ENCODER_WITH_BUTTON_DEBOUNCE_ASSERT_SVH
`define ROTARY_ENCODER_WITH_BUTTON_DEBOUNCE_ASSERT_SVH

// Plain property, sampled on clk_i, off during reset.
`define REB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk_i, off during reset.
`define REB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/reb_pkg.sv
// Shared types and codes for the rotary encoder block.
package reb_pkg;

  typedef enum logic [1:0] {
    DirNone = 2'd0,
    DirCw   = 2'd1,
    DirCcw  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    EvtNone     = 2'd0,
    EvtPressed  = 2'd1,
    EvtReleased = 2'd2
  } evt_e;

  localparam int unsigned PosW = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgButtonPresent = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStartPosition = 1'b1;

  // One sampled request as held in the input stage.
  typedef struct packed {
    logic a;
    logic b;
    logic btn;
  } pin_sample_t;

endpackage

### sv/rotary_encoder_with_button_debounce.sv
// Rotary encoder decoder with button debounce: top level.
//
// Input channel (in_valid_i/in_ready_o) takes one request per sample tick:
// pin_a_i, pin_b_i and button_level_i. Output channel (out_valid_o/
// out_ready_i) returns one result per request: step_direction_o,
// button_event_o and position_now_o, in request order.
// A request lands in an input register, passes through one level of compare
// and increment logic and is written to the result register once that
// register is free. While the receiver does not stall, one request per
// cycle is sustained, since a single combinational pass lies between the
// two registers.
// If the receiver stalls, the result register holds and the input register
// still takes one more request; in_ready_o drops only while both are full.
// Reset clears both stages, the stored pin levels, the position counter,
// the debounce count and button_present. Write the registers through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while idle; writing start_position loads
// the position counter at once.
module rotary_encoder_with_button_debounce #(
  parameter int unsigned DEBOUNCE_LENGTH = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               pin_a_i,
  input  logic                               pin_b_i,
  input  logic                               button_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         step_direction_o,
  output logic [1:0]                         button_event_o,
  output logic signed [reb_pkg::PosW-1:0]    position_now_o,
  input  logic                               cfg_we_i,
  input  logic [reb_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [reb_pkg::PosW-1:0]           cfg_wdata_i
);

  `include "rotary_encoder_with_button_debounce_assert.svh"

  logic                            in_vld_q, in_vld_d;
  reb_pkg::pin_sample_t            sample_q;
  logic                            out_vld_q, out_vld_d;
  reb_pkg::dir_e                   dir_q, dir_d;
  reb_pkg::evt_e                   evt_q, evt_d;
  logic signed [reb_pkg::PosW-1:0] pos_q, pos_d;
  logic                            present_q, present_d;
  logic                            out_free;
  logic                            adv;
  logic                            load;

  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign load       = cfg_we_i && (cfg_idx_i == reb_pkg::CfgStartPosition);

  always_comb begin
    present_d = present_q;
    if (cfg_we_i && (cfg_idx_i == reb_pkg::CfgButtonPresent)) begin
      present_d = cfg_wdata_i[0];
    end
  end

  reb_quad u_quad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .sample_i   (sample_q),
    .load_i     (load),
    .load_val_i (cfg_wdata_i),
    .dir_o      (dir_d),
    .pos_o      (pos_d)
  );

  reb_debounce #(
    .DebounceLength (DEBOUNCE_LENGTH)
  ) u_debounce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .present_i (present_q),
    .sample_i  (sample_q),
    .evt_o     (evt_d)
  );

  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    if (out_free) begin
      out_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      present_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      present_q <= present_d;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q.a   <= pin_a_i;
      sample_q.b   <= pin_b_i;
      sample_q.btn <= button_level_i;
    end
    if (adv) begin
      dir_q <= dir_d;
      evt_q <= evt_d;
      pos_q <= pos_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign step_direction_o = dir_q;
  assign button_event_o   = evt_q;
  assign position_now_o   = pos_q;

  `REB_ASSERT_IMPL(a_evt_needs_button,
    out_valid_o && (button_event_o != reb_pkg::EvtNone), present_q,
    "button event reported with button logic disabled")
  `REB_ASSERT_IMPL(a_ready_only_on_stall, !in_ready_o,
    out_valid_o && !out_ready_i, "input stalled without an output stall")
  `REB_ASSERT_IMPL(a_codes_legal, out_valid_o,
    (step_direction_o != 2'd3) && (button_event_o != 2'd3),
    "illegal direction or event code")
  `REB_ASSERT(a_drain_moves,
    (in_vld_q && out_free) |=> out_valid_o,
    "advanced request did not reach the result register")

endmodule

### sv/reb_quad.sv
// Quadrature decoder: edge detection on A/B and the wrapping position counter.
module reb_quad (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  reb_pkg::pin_sample_t            sample_i,
  input  logic                            load_i,
  input  logic signed [reb_pkg::PosW-1:0] load_val_i,
  output reb_pkg::dir_e                   dir_o,
  output logic signed [reb_pkg::PosW-1:0] pos_o
);

  logic                            last_a_q, last_a_d;
  logic                            last_b_q, last_b_d;
  logic signed [reb_pkg::PosW-1:0] pos_q, pos_d;
  logic                            changed;
  logic                            cw;

  always_comb begin
    changed = (sample_i.a != last_a_q) || (sample_i.b != last_b_q);
    cw      = (sample_i.a != last_b_q);
    dir_o   = reb_pkg::DirNone;
    pos_o   = pos_q;
    if (changed) begin
      if (cw) begin
        dir_o = reb_pkg::DirCw;
        pos_o = pos_q + reb_pkg::PosW'(1);
      end else begin
        dir_o = reb_pkg::DirCcw;
        pos_o = pos_q - reb_pkg::PosW'(1);
      end
    end
  end

  always_comb begin
    last_a_d = last_a_q;
    last_b_d = last_b_q;
    pos_d    = pos_q;
    // The user must load config only while idle so a load never meets an advance; this block does not enforce it.
    if (load_i) begin
      pos_d = load_val_i;
    end else if (en_i) begin
      last_a_d = sample_i.a;
      last_b_d = sample_i.b;
      pos_d    = pos_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
      last_b_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      last_a_q <= last_a_d;
      last_b_q <= last_b_d;
      pos_q    <= pos_d;
    end
  end

endmodule

### sv/reb_debounce.sv
// Button debounce countdown and press/release event generation.
module reb_debounce #(
  parameter int unsigned DebounceLength = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 present_i,
  input  reb_pkg::pin_sample_t sample_i,
  output reb_pkg::evt_e        evt_o
);

  localparam int unsigned CntW = $clog2(DebounceLength + 1);

  logic            last_btn_q, last_btn_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    last_btn_d = last_btn_q;
    cnt_d      = cnt_q;
    evt_o      = reb_pkg::EvtNone;
    if (present_i) begin
      if (sample_i.btn != last_btn_q) begin
        // Arm only when idle; a change mid-count just tracks the level.
        if (cnt_q == '0) begin
          cnt_d = CntW'(DebounceLength);
        end
        last_btn_d = sample_i.btn;
      end else if (cnt_q != '0) begin
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          evt_o = sample_i.btn ? reb_pkg::EvtReleased : reb_pkg::EvtPressed;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_btn_q <= 1'b0;
      cnt_q      <= '0;
    end else if (en_i) begin
      last_btn_q <= last_btn_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

### sim/rotary_encoder_with_button_debounce_tb.sv
// Testbench for the rotary encoder decoder with button debounce.
`timescale 1ns / 100ps

module rotary_encoder_with_button_debounce_tb;

  localparam int unsigned DebounceLen = 5;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseTicks = 106;

  typedef struct packed {
    reb_pkg::dir_e              dir;
    reb_pkg::evt_e              evt;
    logic [reb_pkg::PosW-1:0]   pos;
  } tick_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 pin_a_i;
  logic                 pin_b_i;
  logic                 button_level_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           step_direction_o;
  logic [1:0]           button_event_o;
  logic signed [reb_pkg::PosW-1:0] position_now_o;
  logic                 cfg_we_i;
  logic [reb_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [reb_pkg::PosW-1:0]    cfg_wdata_i;

  // Decoder state as the block should hold it.
  logic                 btn_enable;
  logic                 last_a;
  logic                 last_b;
  logic                 last_btn;
  logic [reb_pkg::PosW-1:0] pos_count;
  int unsigned          debounce_cnt;

  tick_result_t         expected_ticks[$];
  int unsigned          mismatches;
  int unsigned          n_sent;
  int unsigned          n_checked;
  int unsigned          n_cw;
  int unsigned          n_ccw;
  int unsigned          n_press;
  int unsigned          n_release;
  int unsigned          n_cfg;
  int unsigned          idle_cycles;
  int unsigned          stall_left;
  logic                 full_rate;

  rotary_encoder_with_button_debounce #(
    .DEBOUNCE_LENGTH(DebounceLen)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pin_a_i          (pin_a_i),
    .pin_b_i          (pin_b_i),
    .button_level_i   (button_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .step_direction_o (step_direction_o),
    .button_event_o   (button_event_o),
    .position_now_o   (position_now_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic tick_result_t decode_tick(input logic a, input logic b,
                                               input logic btn);
    tick_result_t r;
    r.dir = reb_pkg::DirNone;
    r.evt = reb_pkg::EvtNone;
    if (a != last_a || b != last_b) begin
      if (a != last_b) begin
        pos_count = pos_count + 1'b1;
        r.dir = reb_pkg::DirCw;
      end else begin
        pos_count = pos_count - 1'b1;
        r.dir = reb_pkg::DirCcw;
      end
    end
    last_a = a;
    last_b = b;
    if (btn_enable) begin
      if (btn != last_btn) begin
        // a running count is not restarted by a bounce
        if (debounce_cnt == 0) debounce_cnt = DebounceLen;
        last_btn = btn;
      end else if (debounce_cnt != 0) begin
        debounce_cnt = debounce_cnt - 1;
        if (debounce_cnt == 0) r.evt = btn ? reb_pkg::EvtReleased : reb_pkg::EvtPressed;
      end
    end
    r.pos = pos_count;
    return r;
  endfunction

  // Hold the request until accepted, then queue its expected result.
  task automatic send_tick(input logic a, input logic b, input logic btn);
    int unsigned gap;
    tick_result_t r;
    gap = full_rate ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pin_a_i        <= a;
    pin_b_i        <= b;
    button_level_i <= btn;
    do @(posedge clk_i); while (!in_ready_o);
    r = decode_tick(a, b, btn);
    expected_ticks.push_back(r);
    n_sent++;
    if (r.dir == reb_pkg::DirCw) n_cw++;
    if (r.dir == reb_pkg::DirCcw) n_ccw++;
    if (r.evt == reb_pkg::EvtPressed) n_press++;
    if (r.evt == reb_pkg::EvtReleased) n_release++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [reb_pkg::CfgIdxW-1:0] idx,
                           input logic [reb_pkg::PosW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      reb_pkg::CfgButtonPresent: btn_enable = data[0];
      reb_pkg::CfgStartPosition: pos_count = data;
      default: ;
    endcase
    n_cfg++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_quadrature_steps();
    // button is off after reset, so its toggles must be ignored
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    // both channels flip at once
    send_tick(1'b1, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_position_wrap();
    write_reg(reb_pkg::CfgStartPosition, 32'h7FFF_FFFF);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    wait_drained();
    write_reg(reb_pkg::CfgStartPosition, 32'h8000_0000);
    send_tick(1'b0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_button_debounce();
    write_reg(reb_pkg::CfgButtonPresent, 32'd1);
    // release with a bounce while the count runs
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    repeat (6) send_tick(1'b0, 1'b0, 1'b1);
    // press, then switch the button off mid count; the count must survive
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    wait_drained();
    write_reg(reb_pkg::CfgButtonPresent, 32'd0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    wait_drained();
    write_reg(reb_pkg::CfgButtonPresent, 32'd1);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_ticks();
    logic [reb_pkg::PosW-1:0] starts [8];
    logic            enables [8];
    logic            cw_run;
    logic            btn_target;
    int unsigned     bounce_left;
    int unsigned     r;
    logic            a;
    logic            b;
    logic            btn;
    starts  = '{32'h0000_0000, 32'h7FFF_FFF8, 32'h8000_0008, 32'hFFFF_FFFF,
                $urandom(), 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};
    enables = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    cw_run = 1'b1;
    btn_target = last_btn;
    bounce_left = 0;
    for (int p = 0; p < 8; p++) begin
      write_reg(reb_pkg::CfgButtonPresent, {31'd0, enables[p]});
      write_reg(reb_pkg::CfgStartPosition, starts[p]);
      full_rate = (p == 3);
      for (int i = 0; i < PhaseTicks; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          a = 1'($urandom_range(0, 1));
          b = 1'($urandom_range(0, 1));
        end else if (r < 35) begin
          a = last_a;
          b = last_b;
        end else begin
          if ($urandom_range(0, 99) < 5) cw_run = ~cw_run;
          // advance one Gray code step along the quadrature cycle
          a = cw_run ? ~last_b : last_b;
          b = cw_run ? last_a : ~last_a;
        end
        if ($urandom_range(0, 99) < 4) begin
          btn_target = ~btn_target;
          bounce_left = $urandom_range(0, 4);
        end
        if (r < 15) btn = 1'($urandom_range(0, 1));
        else if (bounce_left != 0) begin
          btn = 1'($urandom_range(0, 1));
          bounce_left--;
        end else btn = btn_target;
        send_tick(a, b, btn);
      end
      wait_drained();
    end
    full_rate = 1'b0;
  endtask

  // Receiver side: random stalls except in the full rate phase.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!full_rate && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        $error("result with no request pending: dir %0d evt %0d pos %0d",
               step_direction_o, button_event_o, position_now_o);
        mismatches++;
      end else begin
        want = expected_ticks.pop_front();
        n_checked++;
        if (step_direction_o !== want.dir) begin
          $error("step_direction: expected %0d, got %0d", want.dir, step_direction_o);
          mismatches++;
        end
        if (button_event_o !== want.evt) begin
          $error("button_event: expected %0d, got %0d", want.evt, button_event_o);
          mismatches++;
        end
        if (position_now_o !== want.pos) begin
          $error("position_now: expected %0d, got %0d", $signed(want.pos), position_now_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("rotary_encoder_with_button_debounce_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    pin_a_i        <= 1'b0;
    pin_b_i        <= 1'b0;
    button_level_i <= 1'b0;
    out_ready_i    <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= reb_pkg::CfgButtonPresent;
    cfg_wdata_i    <= '0;
    btn_enable   = 1'b0;
    last_a       = 1'b0;
    last_b       = 1'b0;
    last_btn     = 1'b0;
    pos_count    = '0;
    debounce_cnt = 0;
    mismatches   = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_cw         = 0;
    n_ccw        = 0;
    n_press      = 0;
    n_release    = 0;
    n_cfg        = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    full_rate    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quadrature_steps();
    test_position_wrap();
    test_button_debounce();
    test_random_ticks();

    wait_drained();
    $display("covered %0d requests (%0d checked) over %0d register writes",
             n_sent, n_checked, n_cfg);
    $display("saw %0d cw and %0d ccw steps, %0d presses and %0d releases",
             n_cw, n_ccw, n_press, n_release);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("rotary_encoder_with_button_debounce_tb OK");
    end else begin
      $display("rotary_encoder_with_button_debounce_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/reb_pkg.sv
sv/reb_quad.sv
sv/reb_debounce.sv
sv/rotary_encoder_with_button_debounce.sv
sim/rotary_encoder_with_button_debounce_tb.sv
